### hw/rtl/rled_pkg.sv
`default_nettype none

package rled_pkg;

    // Byte counts per block never exceed 128, the largest block depth.
    localparam int CNT_W = 8;

    localparam logic [7:0] MARK_B = 8'h42;
    localparam logic [7:0] MARK_U = 8'h55;
    localparam logic [7:0] MARK_D = 8'h44;
    localparam logic [7:0] MARK_A = 8'h41;
    localparam logic [31:0] MARKER_RESET = {MARK_B, MARK_U, MARK_D, MARK_A};

    // One decode job: n bytes of one bank, as run pairs or raw literals.
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             lit;
        logic             ovf;
        logic             bank;
    } job_t;

    // Back end hands a bank back to the front end once fully read.
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

endpackage

`default_nettype wire

### hw/rtl/rled_ram.sv
`default_nettype none

module rled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/rled_job_fifo.sv
`default_nettype none

module rled_job_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire rled_pkg::job_t push_data,
    input  wire logic          pop,
    output rled_pkg::job_t     pop_data,
    output logic               empty,
    output logic               full
);
    import rled_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign empty   = (cnt_reg == 2'd0);
    assign full    = (cnt_reg == 2'd2);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rled_front.sv
`default_nettype none

module rled_front #(
    parameter int BLOCK_DEPTH = 128
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [31:0]                     cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_data_byte,
    input  wire logic                            s_last_byte,
    output logic                                 wr_en,
    output logic [$clog2(BLOCK_DEPTH):0]         wr_addr,
    output logic [7:0]                           wr_data,
    output logic                                 push,
    output rled_pkg::job_t                       push_job,
    input  wire logic                            q_full,
    input  wire rled_pkg::release_t              rel
);
    import rled_pkg::*;

    localparam int ABW         = $clog2(BLOCK_DEPTH);
    localparam int STORE_DEPTH = BLOCK_DEPTH + 4;
    localparam int FW          = $clog2(STORE_DEPTH + 1);

    logic [31:0]   marker_reg, marker_next;
    logic [31:0]   win_reg, win_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic          bank_reg, bank_next;
    logic [1:0]    busy_reg, busy_next;

    logic          accept;
    logic [FW-1:0] fill_inc;
    logic          ovf_inc;
    logic [FW-1:0] pair_bytes;
    logic          hit;

    assign s_ready = !busy_reg[bank_reg] && !q_full;
    assign accept  = s_valid && s_ready;

    // Bytes past the data area only live in the marker window.
    assign wr_en   = accept && (fill_reg < FW'(BLOCK_DEPTH));
    assign wr_addr = {bank_reg, fill_reg[ABW-1:0]};
    assign wr_data = s_data_byte;

    always_comb begin
        marker_next = cfg_we ? cfg_wdata : marker_reg;
        win_next    = win_reg;
        fill_next   = fill_reg;
        ovf_next    = ovf_reg;
        bank_next   = bank_reg;
        busy_next   = busy_reg;
        push        = 1'b0;
        push_job    = '0;

        fill_inc   = (fill_reg < FW'(STORE_DEPTH)) ? fill_reg + FW'(1) : fill_reg;
        ovf_inc    = ovf_reg || (fill_reg == FW'(STORE_DEPTH));
        pair_bytes = (fill_inc - FW'(4)) & ~FW'(1);
        hit        = (fill_inc >= FW'(5)) && ({win_reg[23:0], s_data_byte} == marker_reg);

        if (rel.valid) begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept) begin
            win_next  = {win_reg[23:0], s_data_byte};
            fill_next = fill_inc;
            ovf_next  = ovf_inc;
            if (hit) begin
                fill_next = '0;
                ovf_next  = 1'b0;
                // A block with no full pair gives nothing.
                if (pair_bytes != '0) begin
                    push          = 1'b1;
                    push_job.n    = CNT_W'(pair_bytes);
                    push_job.lit  = 1'b0;
                    push_job.ovf  = ovf_inc;
                    push_job.bank = bank_reg;
                end
            end else if (s_last_byte) begin
                fill_next     = '0;
                ovf_next      = 1'b0;
                push          = 1'b1;
                push_job.n    = (fill_inc > FW'(BLOCK_DEPTH)) ? CNT_W'(BLOCK_DEPTH)
                                                             : CNT_W'(fill_inc);
                push_job.lit  = 1'b1;
                push_job.ovf  = ovf_inc || (fill_inc > FW'(BLOCK_DEPTH));
                push_job.bank = bank_reg;
            end
        end

        if (push) begin
            busy_next[bank_reg] = 1'b1;
            bank_next           = !bank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= MARKER_RESET;
            fill_reg   <= '0;
            ovf_reg    <= 1'b0;
            bank_reg   <= 1'b0;
            busy_reg   <= 2'b00;
        end else begin
            marker_reg <= marker_next;
            fill_reg   <= fill_next;
            ovf_reg    <= ovf_next;
            bank_reg   <= bank_next;
            busy_reg   <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

### hw/rtl/rled_back.sv
`default_nettype none

module rled_back #(
    parameter int BLOCK_DEPTH = 128
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_empty,
    input  wire rled_pkg::job_t              q_data,
    output logic                             q_pop,
    output logic                             rd_en,
    output logic [$clog2(BLOCK_DEPTH):0]     rd_addr,
    input  wire logic [7:0]                  rd_data,
    output rled_pkg::release_t               rel,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [7:0]                       m_first_byte,
    output logic [7:0]                       m_second_byte,
    output logic                             m_is_literal,
    output logic [1:0]                       m_byte_count,
    output logic                             m_last_result,
    output logic                             m_overflow
);
    import rled_pkg::*;

    localparam int ABW = $clog2(BLOCK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD_A = 4'b0010,
        S_RD_B = 4'b0100,
        S_LOAD = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    job_t             job_reg, job_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] idx_sel;
    logic [7:0]       first_reg, first_next;

    logic       m_valid_reg;
    logic [7:0] m_first_reg, m_second_reg;
    logic       m_lit_reg, m_last_reg, m_ovf_reg;
    logic [1:0] m_cnt_reg;

    logic out_free, load, two, last;

    assign out_free = !m_valid_reg || m_ready;
    assign two  = ({1'b0, idx_reg} + (CNT_W+1)'(1)) < {1'b0, job_reg.n};
    assign last = ({1'b0, idx_reg} + (CNT_W+1)'(2)) >= {1'b0, job_reg.n};
    assign rd_addr = {job_reg.bank, idx_sel[ABW-1:0]};

    // Per result: read first byte, read second byte, load output register.
    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        idx_sel    = idx_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rel        = '0;
        load       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    job_next   = q_data;
                    idx_next   = '0;
                    state_next = S_RD_A;
                end
            end
            S_RD_A: begin
                rd_en      = 1'b1;
                state_next = S_RD_B;
            end
            S_RD_B: begin
                idx_sel    = idx_reg + CNT_W'(1);
                rd_en      = two;
                first_next = rd_data;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    load     = 1'b1;
                    idx_next = idx_reg + CNT_W'(2);
                    if (last) begin
                        rel.valid  = 1'b1;
                        rel.bank   = job_reg.bank;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_RD_A;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        idx_reg   <= idx_next;
        first_reg <= first_next;
        if (load) begin
            m_first_reg  <= first_reg;
            m_second_reg <= two ? rd_data : 8'h00;
            m_lit_reg    <= job_reg.lit;
            m_cnt_reg    <= two ? 2'd2 : 2'd1;
            m_last_reg   <= last;
            m_ovf_reg    <= job_reg.ovf;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_first_byte  = m_first_reg;
    assign m_second_byte = m_second_reg;
    assign m_is_literal  = m_lit_reg;
    assign m_byte_count  = m_cnt_reg;
    assign m_last_result = m_last_reg;
    assign m_overflow    = m_ovf_reg;

endmodule

`default_nettype wire

### hw/rtl/marker_block_rle_decoder_core.sv
// Channel  | Direction | Ports                                         | Transaction
// ---------+-----------+-----------------------------------------------+----------------------
// s_       | in        | s_valid s_ready s_data_byte s_last_byte       | one stream byte
// m_       | out       | m_valid m_ready m_first_byte m_second_byte    | one pair / literal
//          |           | m_is_literal m_byte_count m_last_result       |
//          |           | m_overflow                                    |
// cfg_     | in        | cfg_we cfg_wdata                              | marker word write
//
// Input: one byte per cycle while s_ready is high; marker match and block end are resolved
// in the accept cycle. Output: each result is built by the back-end read sequencer on the
// store's single read port (first byte, second byte, output register load).
// The store has two banks: the next block fills one while the previous drains the other;
// s_ready drops only while both banks hold blocks that are not yet fully read.
// Reset is synchronous; the store is not cleared, no clearing pass.
`default_nettype none

module marker_block_rle_decoder_core #(
    parameter int BLOCK_DEPTH = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_first_byte,
    output logic [7:0]       m_second_byte,
    output logic             m_is_literal,
    output logic [1:0]       m_byte_count,
    output logic             m_last_result,
    output logic             m_overflow
);
    import rled_pkg::*;

    localparam int ABW = $clog2(BLOCK_DEPTH);

    logic           wr_en, rd_en;
    logic [ABW:0]   wr_addr, rd_addr;
    logic [7:0]     wr_data, rd_data;
    logic           push, pop, q_empty, q_full;
    job_t           push_job, pop_job;
    release_t       rel;

    rled_front #(.BLOCK_DEPTH(BLOCK_DEPTH)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .push        (push),
        .push_job    (push_job),
        .q_full      (q_full),
        .rel         (rel)
    );

    rled_job_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (q_empty),
        .full      (q_full)
    );

    rled_ram #(.WIDTH(8), .DEPTH(2 ** (ABW + 1))) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    rled_back #(.BLOCK_DEPTH(BLOCK_DEPTH)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_data        (pop_job),
        .q_pop         (pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .rel           (rel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_first_byte  (m_first_byte),
        .m_second_byte (m_second_byte),
        .m_is_literal  (m_is_literal),
        .m_byte_count  (m_byte_count),
        .m_last_result (m_last_result),
        .m_overflow    (m_overflow)
    );

endmodule

`default_nettype wire

### hw/rtl/rled_checker.sv
`default_nettype none

module rled_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_first_byte,
    input wire logic [7:0] m_second_byte,
    input wire logic       m_is_literal,
    input wire logic [1:0] m_byte_count,
    input wire logic       m_last_result
);

    // Stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_first_byte) && $stable(m_second_byte)
            && $stable(m_byte_count) && $stable(m_last_result))
        else $error("result changed while stalled");

    a_pair_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_literal |-> m_byte_count == 2'd2)
        else $error("run pair without two bytes");

    // A single-byte literal only closes an odd tail.
    a_odd_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_count == 2'd1 |-> m_is_literal && m_last_result
            && m_second_byte == 8'h00)
        else $error("bad single-byte literal");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_byte_count == 2'd1 || m_byte_count == 2'd2)
        else $error("byte count out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind marker_block_rle_decoder_core rled_checker u_rled_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_first_byte  (m_first_byte),
    .m_second_byte (m_second_byte),
    .m_is_literal  (m_is_literal),
    .m_byte_count  (m_byte_count),
    .m_last_result (m_last_result)
);

`default_nettype wire
